[design/mcwf_pkg.sv]
// Package: shared constants and types for the minimum covering window finder.
`timescale 1ns / 1ps
`default_nettype none
package mcwf_pkg;
  localparam int MAX_TEXT_DEF    = 4096;
  localparam int MAX_PATTERN_DEF = 4096;
  localparam int ALPHABET_DEF    = 128;
  localparam int CH_W            = 7;

  typedef enum logic [1:0] {
    OP_PATTERN = 2'd0,
    OP_TEXT    = 2'd1,
    OP_END     = 2'd2,
    OP_NONE    = 2'd3
  } op_t;
endpackage
`default_nettype wire

[design/mcwf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module mcwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/min_covering_window_finder_unit.sv]
// Top level: minimum covering window finder, sequenced over shared RAMs.
// A pattern item passes through states RD, WAIT and UPD; a text item through
// RD, WAIT, UPD and CHK, then SRD, SWAIT, SUPD and CHK per left shrink step
// (amortised one per text item); an end item goes through OUT. Result held in
// an output register; an end item waits in its output state while an earlier
// result is unaccepted. Reset: synchronous; after reset a clear pass over the
// count memories runs with tready low. The same pass follows every end item.
`timescale 1ns / 1ps
`default_nettype none
module min_covering_window_finder_unit
  import mcwf_pkg::*;
#(
  parameter int MAX_TEXT    = MAX_TEXT_DEF,
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int ALPHABET    = ALPHABET_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // ch[6:0]
  input  wire logic [1:0]  s_tuser,   // op[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // found, win_start[12:1], win_length[25:13], overflow[26]
);
  localparam int AW  = $clog2(ALPHABET);
  localparam int TW  = $clog2(MAX_TEXT + 1);
  localparam int TAW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int PW  = $clog2(MAX_PATTERN + 1);
  localparam int CW  = (TW > PW) ? TW : PW;
  localparam int DW  = PW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_WAIT, S_UPD, S_CHK, S_SRD, S_SWAIT, S_SUPD, S_OUT
  } state_t;

  state_t state;
  logic [1:0]    op;
  logic [CH_W-1:0] cur;
  logic [AW-1:0] clr_idx;
  logic [PW-1:0] pat_len;
  logic [TW-1:0] left_pos, text_cnt;
  logic [DW-1:0] deficit;
  logic [11:0]   best_start;
  logic [12:0]   best_len;
  logic          have_best, dropped;

  logic          pc_we, wc_we, wch_we;
  logic [AW-1:0] pc_waddr, raddr;
  logic [CW-1:0] pc_wdata, wc_wdata, pc_rd, wc_rd;
  logic [CH_W-1:0] wch_rd;
  logic [TW-1:0] len;
  logic [CW-1:0] wc_inc, wc_dec;
  logic          res_found;

  mcwf_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_pc (
    .clk, .we(pc_we), .waddr(pc_waddr), .wdata(pc_wdata), .raddr(raddr), .rdata(pc_rd));
  mcwf_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_wc (
    .clk, .we(wc_we), .waddr(pc_waddr), .wdata(wc_wdata), .raddr(raddr), .rdata(wc_rd));
  mcwf_ram #(.WIDTH(CH_W), .DEPTH(MAX_TEXT)) u_wch (
    .clk, .we(wch_we), .waddr(text_cnt[TAW-1:0]), .wdata(cur),
    .raddr(left_pos[TAW-1:0]), .rdata(wch_rd));

  // leftmost character addresses the counts as soon as it is read
  assign raddr     = (state == S_SWAIT) ? AW'(wch_rd) : AW'(cur);
  assign len       = text_cnt - left_pos;
  assign wc_inc    = wc_rd + CW'(1);
  assign wc_dec    = wc_rd - CW'(1);
  assign res_found = have_best && pat_len != '0;

  always_comb begin
    pc_we    = 1'b0;
    wc_we    = 1'b0;
    wch_we   = 1'b0;
    pc_waddr = AW'(cur);
    pc_wdata = pc_rd + CW'(1);
    wc_wdata = wc_inc;
    if (state == S_CLR) begin
      pc_we = 1'b1; wc_we = 1'b1; pc_waddr = clr_idx;
      pc_wdata = '0; wc_wdata = '0;
    end else if (state == S_UPD && op == OP_PATTERN) begin
      pc_we = 1'b1;
    end else if (state == S_UPD) begin
      wc_we = 1'b1; wch_we = 1'b1;
    end else if (state == S_SUPD) begin
      wc_we = 1'b1; wc_wdata = wc_dec;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_idx <= '0; m_tvalid <= 1'b0;
      pat_len <= '0; left_pos <= '0; text_cnt <= '0; deficit <= '0;
      best_start <= '0; best_len <= '0; have_best <= 1'b0; dropped <= 1'b0;
      op <= OP_NONE; cur <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == AW'(ALPHABET - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op  <= s_tuser;
            cur <= s_tdata[CH_W-1:0];
            case (s_tuser)
              OP_PATTERN: begin
                if (pat_len == PW'(MAX_PATTERN)) dropped <= 1'b1;
                else state <= S_RD;
              end
              OP_TEXT: begin
                if (text_cnt == TW'(MAX_TEXT)) dropped <= 1'b1;
                else state <= S_RD;
              end
              OP_END: state <= S_OUT;
              default: ;
            endcase
          end
        end
        S_RD:   state <= S_WAIT;
        S_WAIT: state <= S_UPD;
        S_UPD: begin
          if (op == OP_PATTERN) begin
            pat_len <= pat_len + PW'(1);
            if (wc_rd < pc_rd + CW'(1)) deficit <= deficit + DW'(1);
            state <= S_IDLE;
          end else begin
            text_cnt <= text_cnt + TW'(1);
            if (wc_inc <= pc_rd) deficit <= deficit - DW'(1);
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (deficit == '0 && left_pos < text_cnt) begin
            if (!have_best || 13'(len) < best_len) begin
              have_best  <= 1'b1;
              best_len   <= 13'(len);
              best_start <= 12'(left_pos);
            end
            state <= S_SRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SRD: state <= S_SWAIT;
        S_SWAIT: begin
          cur   <= wch_rd;
          state <= S_SUPD;
        end
        S_SUPD: begin
          if (wc_dec < pc_rd) deficit <= deficit + DW'(1);
          left_pos <= left_pos + TW'(1);
          state    <= S_CHK;
        end
        S_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, dropped, res_found ? best_len : 13'd0,
                         res_found ? best_start : 12'd0, res_found};
            pat_len <= '0; left_pos <= '0; text_cnt <= '0; deficit <= '0;
            best_start <= '0; best_len <= '0; have_best <= 1'b0; dropped <= 1'b0;
            clr_idx <= '0;
            state <= S_CLR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(state == S_CLR)) else $error("ready during clear");
  a_left_le_text: assert property (@(posedge clk) disable iff (rst)
    left_pos <= text_cnt) else $error("left beyond text");
  a_out_once: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result lost");
endmodule
`default_nettype wire

[tb/mcwf_checker.sv]
// Checker: predicts covering-window results from the observed input items and compares them.
`timescale 1ns / 1ps
module mcwf_checker
  import mcwf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,
  output int               errors,
  output int               pending
);
  typedef struct packed {
    logic        found;
    logic [11:0] win_start;
    logic [12:0] win_length;
    logic        overflow;
  } window_result_t;

  window_result_t expected_windows[$];

  int unsigned pat_cnt[ALPHABET_DEF];
  int unsigned win_cnt[ALPHABET_DEF];
  logic [6:0]  text_buf[MAX_TEXT_DEF];
  int unsigned pat_len, left_idx, text_len, best_pos, best_len, lacking;
  bit          best_valid, dropped;

  function automatic void clear_window_state();
    foreach (pat_cnt[i]) begin
      pat_cnt[i] = 0;
      win_cnt[i] = 0;
    end
    pat_len = 0; left_idx = 0; text_len = 0; best_pos = 0; best_len = 0;
    lacking = 0; best_valid = 0; dropped = 0;
  endfunction

  function automatic void take_item(op_t op, logic [6:0] c);
    window_result_t r;
    int unsigned d;
    case (op)
      OP_PATTERN: begin
        if (pat_len >= MAX_PATTERN_DEF) dropped = 1;
        else begin
          pat_len++;
          pat_cnt[c]++;
          if (win_cnt[c] < pat_cnt[c]) lacking++;
        end
      end
      OP_TEXT: begin
        if (text_len >= MAX_TEXT_DEF) dropped = 1;
        else begin
          text_buf[text_len] = c;
          text_len++;
          win_cnt[c]++;
          if (win_cnt[c] <= pat_cnt[c]) lacking--;
          while (lacking == 0 && left_idx < text_len) begin
            if (!best_valid || text_len - left_idx < best_len) begin
              best_valid = 1;
              best_len = text_len - left_idx;
              best_pos = left_idx;
            end
            d = text_buf[left_idx];
            win_cnt[d]--;
            if (win_cnt[d] < pat_cnt[d]) lacking++;
            left_idx++;
          end
        end
      end
      OP_END: begin
        r.found = best_valid && pat_len != 0;
        r.win_start = r.found ? best_pos[11:0] : '0;
        r.win_length = r.found ? best_len[12:0] : '0;
        r.overflow = dropped;
        expected_windows.push_back(r);
        clear_window_state();
      end
      default: ;
    endcase
  endfunction

  initial clear_window_state();

  always @(posedge clk) begin
    window_result_t got, want;
    if (rst) begin
      errors <= 0;
      expected_windows.delete();
      clear_window_state();
    end else begin
      if (s_tvalid && s_tready) take_item(op_t'(s_tuser), s_tdata[6:0]);
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[12:1], m_tdata[25:13], m_tdata[26]};
        if (expected_windows.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result %h", m_tdata);
        end else begin
          want = expected_windows.pop_front();
          if (got !== want) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: exp f=%0d s=%0d l=%0d o=%0d got f=%0d s=%0d l=%0d o=%0d",
                       want.found, want.win_start, want.win_length, want.overflow,
                       got.found, got.win_start, got.win_length, got.overflow);
          end
        end
      end
    end
    pending = expected_windows.size();
  end
endmodule

[tb/tb_min_covering_window_finder_unit.sv]
// Testbench top: drives pattern, text, end and no-op items into the window finder and gives the verdict.
`timescale 1ns / 1ps
module tb_min_covering_window_finder_unit;
  import mcwf_pkg::*;

  logic        clk = 0, rst = 1;
  logic        s_tvalid = 0, m_tready = 0;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  wire         s_tready, m_tvalid;
  wire  [31:0] m_tdata;
  int          errors, pending;
  int          sent = 0;
  bit          calm = 0, hold = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  min_covering_window_finder_unit DUT (.*);

  mcwf_checker u_chk (.*);

  // called and returning at a falling edge; tready is stable until the next rising edge
  task automatic send_item(op_t op, logic [6:0] c);
    if (!calm && $urandom_range(99) < 26) begin
      s_tvalid <= 0;
      @(negedge clk);
      while (!calm && $urandom_range(99) < 26) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, c};
    while (!s_tready) @(negedge clk);
    @(negedge clk);
    sent++;
  endtask

  // random job: mostly a small alphabet so windows are found
  task automatic random_job();
    int np, nt, span;
    span = $urandom_range(1, 3) == 1 ? 128 : $urandom_range(2, 8);
    np = $urandom_range(0, 4);
    nt = $urandom_range(0, 24);
    for (int i = 0; i < np; i++) send_item(OP_PATTERN, 7'($urandom_range(span - 1)));
    for (int i = 0; i < nt; i++) begin
      case ($urandom_range(19))
        0: send_item(OP_PATTERN, 7'($urandom_range(span - 1)));
        1: send_item(OP_NONE, 7'($urandom_range(127)));
        default: send_item(OP_TEXT, 7'($urandom_range(span - 1)));
      endcase
    end
    send_item(OP_END, 7'($urandom_range(127)));
  endtask

  always begin
    @(negedge clk);
    if (hold) m_tready <= 0;
    else m_tready <= calm || $urandom_range(99) >= 26;
  end

  initial begin
    #200000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 0;
    // directed
    send_item(OP_END, 7'h7f);
    send_item(OP_TEXT, 7'h00); send_item(OP_END, 7'h00);
    send_item(OP_PATTERN, 7'h7f); send_item(OP_PATTERN, 7'h00);
    send_item(OP_TEXT, 7'h00); send_item(OP_TEXT, 7'h55); send_item(OP_TEXT, 7'h7f);
    send_item(OP_TEXT, 7'h00); send_item(OP_END, 7'h00);
    send_item(OP_PATTERN, 7'h2a); send_item(OP_TEXT, 7'h2a);
    send_item(OP_PATTERN, 7'h2a); send_item(OP_TEXT, 7'h01); send_item(OP_TEXT, 7'h2a);
    send_item(OP_NONE, 7'h2a); send_item(OP_END, 7'h00);
    send_item(OP_PATTERN, 7'h05); send_item(OP_END, 7'h00);
    // long back-pressure: end items stall while receiver holds off
    hold = 1;
    n = 0;
    fork
      begin repeat (400) @(posedge clk); hold = 0; end
      repeat (6) random_job();
    join
    n = sent;
    while (sent - n < 640) begin
      calm = (sent - n > 260 && sent - n < 380);
      random_job();
    end
    calm = 0;
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

[filelist.f]
design/mcwf_pkg.sv
design/mcwf_ram.sv
design/min_covering_window_finder_unit.sv
tb/mcwf_checker.sv
tb/tb_min_covering_window_finder_unit.sv
